>>> hw/rtl/bis_pkg.sv
// Shared types, constants and helpers for the bilinear image sampler.
// Used by every module of the block; depends on nothing else.
package bis_pkg;

    localparam int DEF_MAX_LINES  = 512;
    localparam int DEF_MAX_SAMPS  = 512;
    localparam int DEF_PIXEL_BITS = 16;
    localparam int DEF_FRAC_BITS  = 8;

    localparam int QUERY_W    = 18;
    localparam int PIX_ADDR_W = 9;
    localparam int PIX_VAL_W  = 16;
    localparam int VALUE_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int CNT_W      = 10;
    localparam int NODATA_W   = 16;

    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 16;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_NUM_LINES = 2'd0,
        REG_NUM_SAMPS = 2'd1,
        REG_NODATA    = 2'd2
    } reg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_OOB    = 2'd1,
        STATUS_NODATA = 2'd2
    } status_t;

    typedef struct packed {
        logic valid;
        logic query;
        logic wr;
        logic oob;
    } ctl_t;

    typedef struct packed {
        logic                 valid;
        logic [VALUE_W-1:0]   value;
        status_t              status;
    } res_t;

    function automatic int idx_bits(input int n);
        return (n > 2) ? $clog2(n) : 2;
    endfunction

endpackage

>>> hw/rtl/bis_decode.sv
// First pipeline stage: bounds check, corner and neighbor indexes, fractions.
// Depends on bis_pkg.
module bis_decode
    import bis_pkg::*;
#(
    parameter int MAX_LINES  = DEF_MAX_LINES,
    parameter int MAX_SAMPS  = DEF_MAX_SAMPS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    localparam int LINE_W    = idx_bits(MAX_LINES),
    localparam int SAMP_W    = idx_bits(MAX_SAMPS)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic                      in_func,
    input  logic [PIX_ADDR_W-1:0]     pix_line,
    input  logic [PIX_ADDR_W-1:0]     pix_samp,
    input  logic [PIX_VAL_W-1:0]      pix_value,
    input  logic signed [QUERY_W-1:0] query_line,
    input  logic signed [QUERY_W-1:0] query_samp,
    input  logic [CNT_W-1:0]          num_lines,
    input  logic [CNT_W-1:0]          num_samps,
    output ctl_t                      ctl,
    output logic [LINE_W-1:0]         line1,
    output logic [LINE_W-1:0]         line2,
    output logic [SAMP_W-1:0]         samp1,
    output logic [SAMP_W-1:0]         samp2,
    output logic [FRAC_BITS-1:0]      frac_a,
    output logic [FRAC_BITS-1:0]      frac_b,
    output logic [PIXEL_BITS-1:0]     wdata
);

    localparam int QI_W = QUERY_W - 1 - FRAC_BITS;
    localparam int CW   = ((QI_W > CNT_W) ? QI_W : CNT_W) + 1;
    localparam logic [CNT_W-1:0] NL_CAP =
        (MAX_LINES < (1 << CNT_W)) ? CNT_W'(MAX_LINES) : '1;
    localparam logic [CNT_W-1:0] NS_CAP =
        (MAX_SAMPS < (1 << CNT_W)) ? CNT_W'(MAX_SAMPS) : '1;

    logic [QI_W-1:0]      li;
    logic [QI_W-1:0]      si;
    logic [FRAC_BITS-1:0] fa;
    logic [FRAC_BITS-1:0] fb;
    logic [CNT_W-1:0]     nl_eff;
    logic [CNT_W-1:0]     ns_eff;
    logic [CW-1:0]        li_p1;
    logic [CW-1:0]        si_p1;
    logic                 line_lt;
    logic                 line_eq;
    logic                 samp_lt;
    logic                 line_ok;
    logic                 samp_ok;
    logic                 pix_in_range;

    ctl_t                  ctl_reg,   ctl_next;
    logic [LINE_W-1:0]     line1_reg, line1_next;
    logic [LINE_W-1:0]     line2_reg, line2_next;
    logic [SAMP_W-1:0]     samp1_reg, samp1_next;
    logic [SAMP_W-1:0]     samp2_reg, samp2_next;
    logic [FRAC_BITS-1:0]  fa_reg;
    logic [FRAC_BITS-1:0]  fb_reg;
    logic [PIXEL_BITS-1:0] wdata_reg;

    assign li = query_line[QUERY_W-2:FRAC_BITS];
    assign si = query_samp[QUERY_W-2:FRAC_BITS];
    assign fa = query_line[FRAC_BITS-1:0];
    assign fb = query_samp[FRAC_BITS-1:0];

    assign nl_eff = (num_lines > NL_CAP) ? NL_CAP : num_lines;
    assign ns_eff = (num_samps > NS_CAP) ? NS_CAP : num_samps;

    assign li_p1 = CW'(li) + CW'(1);
    assign si_p1 = CW'(si) + CW'(1);

    // A non-negative position is inside when its integer part plus one stays
    // below the count; a line position may also sit exactly on the last line.
    assign line_lt = li_p1 < CW'(nl_eff);
    assign line_eq = li_p1 == CW'(nl_eff);
    assign samp_lt = si_p1 < CW'(ns_eff);
    assign line_ok = !query_line[QUERY_W-1] && (line_lt || (line_eq && (fa == '0)));
    assign samp_ok = !query_samp[QUERY_W-1] && samp_lt;

    assign pix_in_range = (int'(pix_line) < MAX_LINES) && (int'(pix_samp) < MAX_SAMPS);

    always_comb begin
        ctl_next.valid = in_valid;
        ctl_next.query = in_func;
        ctl_next.wr    = !in_func && pix_in_range;
        ctl_next.oob   = !(line_ok && samp_ok);
        if (in_func) begin
            line1_next = LINE_W'(li);
            line2_next = line_lt ? LINE_W'(li_p1) : LINE_W'(li);
            samp1_next = SAMP_W'(si);
            samp2_next = SAMP_W'(si_p1);
        end else begin
            line1_next = LINE_W'(pix_line);
            line2_next = LINE_W'(pix_line);
            samp1_next = SAMP_W'(pix_samp);
            samp2_next = SAMP_W'(pix_samp);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            line1_reg <= line1_next;
            line2_reg <= line2_next;
            samp1_reg <= samp1_next;
            samp2_reg <= samp2_next;
            fa_reg    <= fa;
            fb_reg    <= fb;
            wdata_reg <= PIXEL_BITS'(pix_value);
        end
    end

    assign ctl    = ctl_reg;
    assign line1  = line1_reg;
    assign line2  = line2_reg;
    assign samp1  = samp1_reg;
    assign samp2  = samp2_reg;
    assign frac_a = fa_reg;
    assign frac_b = fb_reg;
    assign wdata  = wdata_reg;

endmodule

>>> hw/rtl/bis_store.sv
// Image store split into four banks by line and sample parity, so that the
// four neighbors of a query are read in parallel. Depends on bis_pkg.
module bis_store
    import bis_pkg::*;
#(
    parameter int MAX_LINES  = DEF_MAX_LINES,
    parameter int MAX_SAMPS  = DEF_MAX_SAMPS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    localparam int LINE_W    = idx_bits(MAX_LINES),
    localparam int SAMP_W    = idx_bits(MAX_SAMPS)
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic                  wr_en,
    input  logic [LINE_W-1:0]     line1,
    input  logic [LINE_W-1:0]     line2,
    input  logic [SAMP_W-1:0]     samp1,
    input  logic [SAMP_W-1:0]     samp2,
    input  logic [PIXEL_BITS-1:0] wdata,
    output logic [PIXEL_BITS-1:0] rd_data [4]
);

    localparam int ADDR_W     = LINE_W + SAMP_W - 2;
    localparam int BANK_DEPTH = 1 << ADDR_W;

    logic [1:0]        wr_bank;
    logic [ADDR_W-1:0] wr_addr;

    assign wr_bank = {line1[0], samp1[0]};
    assign wr_addr = {line1[LINE_W-1:1], samp1[SAMP_W-1:1]};

    for (genvar g = 0; g < 4; g++) begin : g_bank
        localparam logic [1:0] BANK_ID = 2'(g);

        logic [PIXEL_BITS-1:0] bank_mem [BANK_DEPTH];
        logic [LINE_W-1:0]     rd_line;
        logic [SAMP_W-1:0]     rd_samp;
        logic [ADDR_W-1:0]     rd_addr;
        logic [PIXEL_BITS-1:0] rd_data_reg;

        // Each bank serves whichever neighbor line and sample has its parity.
        assign rd_line = (line1[0] == BANK_ID[1]) ? line1 : line2;
        assign rd_samp = (samp1[0] == BANK_ID[0]) ? samp1 : samp2;
        assign rd_addr = {rd_line[LINE_W-1:1], rd_samp[SAMP_W-1:1]};

        always_ff @(posedge aclk) begin
            if (en && wr_en && (wr_bank == BANK_ID)) begin
                bank_mem[wr_addr] <= wdata;
            end
            if (en) begin
                rd_data_reg <= bank_mem[rd_addr];
            end
        end

        assign rd_data[g] = rd_data_reg;
    end

endmodule

>>> hw/rtl/bis_blend.sv
// Weight, neighbor-product and summing stages of the bilinear blend, with the
// nodata check and result status. Depends on bis_pkg.
module bis_blend
    import bis_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  ctl_t                  in_ctl,
    input  logic [FRAC_BITS-1:0]  frac_a,
    input  logic [FRAC_BITS-1:0]  frac_b,
    input  logic [3:0]            parity,
    input  logic [PIXEL_BITS-1:0] rd_data [4],
    input  logic [NODATA_W-1:0]   nodata_value,
    output res_t                  res
);

    localparam int WW     = 2 * FRAC_BITS + 1;
    localparam int WF_W   = 2 * FRAC_BITS + 2;
    localparam int PF_W   = WW + PIXEL_BITS;
    localparam int SUM_W  = 2 * FRAC_BITS + PIXEL_BITS;
    localparam int CMP_W  = (PIXEL_BITS > NODATA_W) ? PIXEL_BITS : NODATA_W;
    localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

    logic [FRAC_BITS:0]    na;
    logic [FRAC_BITS:0]    nb;
    logic [FRAC_BITS:0]    ea;
    logic [FRAC_BITS:0]    eb;
    logic [WF_W-1:0]       w_full [4];

    logic                  v2_reg;
    logic                  oob2_reg;
    logic [3:0]            par2_reg;
    logic [WW-1:0]         w2_reg [4];

    logic [1:0]            pix_sel [4];
    logic [PIXEL_BITS-1:0] pix [4];
    logic [PF_W-1:0]       prod_full [4];
    logic                  nd_hit;

    logic                  v3_reg;
    logic                  oob3_reg;
    logic                  nd3_reg;
    logic [SUM_W-1:0]      prod3_reg [4];

    logic [SUM_W-1:0]      sum;
    res_t                  res_reg, res_next;

    // Stage 2: corner weights, in step with the store read.
    assign ea = {1'b0, frac_a};
    assign eb = {1'b0, frac_b};
    assign na = ONE_FX - ea;
    assign nb = ONE_FX - eb;

    assign w_full[0] = na * nb;
    assign w_full[1] = na * eb;
    assign w_full[2] = ea * nb;
    assign w_full[3] = ea * eb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= in_ctl.valid && in_ctl.query;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            oob2_reg <= in_ctl.oob;
            par2_reg <= parity;
            for (int i = 0; i < 4; i++) begin
                w2_reg[i] <= w_full[i][WW-1:0];
            end
        end
    end

    // Stage 3: route bank data to the four corners, check nodata, multiply.
    // parity holds the low bits of the lower line, next line, lower sample
    // and next sample, from the top bit down.
    assign pix_sel[0] = {par2_reg[3], par2_reg[1]};
    assign pix_sel[1] = {par2_reg[3], par2_reg[0]};
    assign pix_sel[2] = {par2_reg[2], par2_reg[1]};
    assign pix_sel[3] = {par2_reg[2], par2_reg[0]};

    always_comb begin
        nd_hit = 1'b0;
        for (int i = 0; i < 4; i++) begin
            pix[i]       = rd_data[pix_sel[i]];
            prod_full[i] = w2_reg[i] * pix[i];
            if (CMP_W'(pix[i]) == CMP_W'(nodata_value)) begin
                nd_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            oob3_reg <= oob2_reg;
            nd3_reg  <= nd_hit;
            for (int i = 0; i < 4; i++) begin
                prod3_reg[i] <= prod_full[i][SUM_W-1:0];
            end
        end
    end

    // Stage 4: sum, drop the fraction bits and form the status.
    assign sum = prod3_reg[0] + prod3_reg[1] + prod3_reg[2] + prod3_reg[3];

    always_comb begin
        res_next.valid = v3_reg;
        if (oob3_reg) begin
            res_next.value  = '0;
            res_next.status = STATUS_OOB;
        end else if (nd3_reg) begin
            res_next.value  = '0;
            res_next.status = STATUS_NODATA;
        end else begin
            res_next.value  = VALUE_W'(sum[SUM_W-1:2*FRAC_BITS]);
            res_next.status = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.valid <= 1'b0;
        end else if (en) begin
            res_reg.valid <= res_next.valid;
        end
        if (en) begin
            res_reg.value  <= res_next.value;
            res_reg.status <= res_next.status;
        end
    end

    assign res = res_reg;

endmodule

>>> hw/rtl/bis_skid.sv
// Output register with a one-beat skid slot, decoupling the pipeline enable
// from the downstream tready. Depends on bis_pkg.
module bis_skid
    import bis_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  res_t                 in_res,
    output logic                 in_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]  m_tuser
);

    logic out_valid_reg,  out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_data_reg,   out_data_next;
    res_t skid_data_reg,  skid_data_next;
    logic out_free;
    logic push;

    assign in_ready = !skid_valid_reg;
    assign push     = in_res.valid && in_ready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_free) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (out_free) begin
                out_valid_next = 1'b1;
                out_data_next  = in_res;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_res;
            end
        end else if (out_free) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg.value;
    assign m_tuser  = out_data_reg.status;

endmodule

>>> hw/rtl/bilinear_image_sampler.sv
// Bilinear image sampler: top level with the register port and pipeline.
// Depends on bis_pkg, bis_decode, bis_store, bis_blend and bis_skid.
//
// Input beats on the s_ channel either write one pixel into the image store
// (s_tuser low) or query an interpolated value at a signed fixed-point line
// and sample position (s_tuser high). A write beat gives no output beat; a
// query gives exactly one beat on the m_ channel, carrying the value in
// m_tdata and the status in m_tuser, in the order the queries were taken.
// While s_tready is high the pipeline takes one beat every cycle: decode
// and bounds check, banked store read with the weight multiply, neighbor
// products, sum. The store has four banks by line and sample parity, one
// write and one read each per cycle. When m_tready is low, a result stays
// on the output and one more is kept in a skid slot, so the pipeline keeps
// going for that beat; after that s_tready drops and every stage holds
// until the output drains. Reset clears the pipeline and sets the line and
// sample counts to 512 and the nodata value to 0; the image store keeps
// whatever it held, and a pixel must be written before a query reads it.
// Registers must be written over the APB port only while no query is in
// flight; the block itself does not enforce this.
module bilinear_image_sampler
    import bis_pkg::*;
#(
    parameter int MAX_LINES  = DEF_MAX_LINES,
    parameter int MAX_SAMPS  = DEF_MAX_SAMPS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [8:0] pix_line, [17:9] pix_samp, [33:18] pix_value,
    // [51:34] query_line, [69:52] query_samp, [71:70] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] func
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] value
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic [STATUS_W-1:0]   m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LINE_W = idx_bits(MAX_LINES);
    localparam int SAMP_W = idx_bits(MAX_SAMPS);

    logic [CNT_W-1:0]    num_lines_reg;
    logic [CNT_W-1:0]    num_samps_reg;
    logic [NODATA_W-1:0] nodata_reg;
    logic                cfg_wr;
    reg_idx_t            cfg_idx;

    logic                  en;
    logic                  in_valid;
    ctl_t                  st1_ctl;
    logic [LINE_W-1:0]     line1;
    logic [LINE_W-1:0]     line2;
    logic [SAMP_W-1:0]     samp1;
    logic [SAMP_W-1:0]     samp2;
    logic [FRAC_BITS-1:0]  frac_a;
    logic [FRAC_BITS-1:0]  frac_b;
    logic [PIXEL_BITS-1:0] wdata;
    logic [PIXEL_BITS-1:0] rd_data [4];
    res_t                  blend_res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_lines_reg <= CNT_W'(512);
            num_samps_reg <= CNT_W'(512);
            nodata_reg    <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_NUM_LINES: num_lines_reg <= pwdata[CNT_W-1:0];
                REG_NUM_SAMPS: num_samps_reg <= pwdata[CNT_W-1:0];
                REG_NODATA:    nodata_reg    <= pwdata[NODATA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_NUM_LINES: prdata = APB_DATA_W'(num_lines_reg);
            REG_NUM_SAMPS: prdata = APB_DATA_W'(num_samps_reg);
            REG_NODATA:    prdata = APB_DATA_W'(nodata_reg);
            default:       prdata = '0;
        endcase
    end

    assign s_tready = en;
    assign in_valid = s_tvalid && en;

    bis_decode #(
        .MAX_LINES  (MAX_LINES),
        .MAX_SAMPS  (MAX_SAMPS),
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (in_valid),
        .in_func    (s_tuser),
        .pix_line   (s_tdata[8:0]),
        .pix_samp   (s_tdata[17:9]),
        .pix_value  (s_tdata[33:18]),
        .query_line (s_tdata[51:34]),
        .query_samp (s_tdata[69:52]),
        .num_lines  (num_lines_reg),
        .num_samps  (num_samps_reg),
        .ctl        (st1_ctl),
        .line1      (line1),
        .line2      (line2),
        .samp1      (samp1),
        .samp2      (samp2),
        .frac_a     (frac_a),
        .frac_b     (frac_b),
        .wdata      (wdata)
    );

    bis_store #(
        .MAX_LINES  (MAX_LINES),
        .MAX_SAMPS  (MAX_SAMPS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_store (
        .aclk    (aclk),
        .en      (en),
        .wr_en   (st1_ctl.valid && st1_ctl.wr),
        .line1   (line1),
        .line2   (line2),
        .samp1   (samp1),
        .samp2   (samp2),
        .wdata   (wdata),
        .rd_data (rd_data)
    );

    bis_blend #(
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_blend (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_ctl       (st1_ctl),
        .frac_a       (frac_a),
        .frac_b       (frac_b),
        .parity       ({line1[0], line2[0], samp1[0], samp2[0]}),
        .rd_data      (rd_data),
        .nodata_value (nodata_reg),
        .res          (blend_res)
    );

    bis_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_res   (blend_res),
        .in_ready (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> tb/tb_bilinear_image_sampler.sv
// Self-checking testbench for bilinear_image_sampler: pixel writes and interpolation
// queries on the stream port, register setup over APB, results checked by a built-in predictor or pinned values.
// Depends on bis_pkg and the bilinear_image_sampler RTL only.
`timescale 1ns / 100ps

module tb_bilinear_image_sampler;
    import bis_pkg::*;

    localparam int IMG_LINES       = DEF_MAX_LINES;
    localparam int IMG_SAMPS       = DEF_MAX_SAMPS;
    localparam int FRAC            = DEF_FRAC_BITS;
    localparam int ONE             = 1 << FRAC;
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 300000;
    localparam logic FUNC_WRITE    = 1'b0;
    localparam logic FUNC_QUERY    = 1'b1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } sample_t;

    typedef struct packed {
        logic                  func;
        logic [PIX_ADDR_W-1:0] line;
        logic [PIX_ADDR_W-1:0] samp;
        logic [PIX_VAL_W-1:0]  pix;
        logic [QUERY_W-1:0]    ql;
        logic [QUERY_W-1:0]    qs;
        logic                  pinned;
        sample_t               result;
    } dir_row_t;

    typedef struct packed {
        logic [CNT_W-1:0]    lines;
        logic [CNT_W-1:0]    samps;
        logic [NODATA_W-1:0] nodata;
        int                  items;
    } phase_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic [PIX_VAL_W-1:0]  img_shadow [IMG_LINES*IMG_SAMPS];
    bit                    pix_written [IMG_LINES*IMG_SAMPS];
    logic [CNT_W-1:0]      lines_cfg = 10'd512;
    logic [CNT_W-1:0]      samps_cfg = 10'd512;
    logic [NODATA_W-1:0]   nodata_cfg = '0;
    sample_t               pending_samples [$];
    int                    err_count = 0;
    int                    cycle_count = 0;
    int                    burst_left = 0;
    int                    beats_sent = 0;
    int                    phase_start = 0;
    bit                    hold_off_req = 1'b0;

    dir_row_t dir_rows [19] = '{
        '{FUNC_WRITE, 9'd0,   9'd0,   16'd100,   18'h00000, 18'h00000, 1'b0, '{16'd0, STATUS_OK}},
        '{FUNC_WRITE, 9'd0,   9'd1,   16'd200,   18'h00000, 18'h00000, 1'b0, '{16'd0, STATUS_OK}},
        '{FUNC_WRITE, 9'd1,   9'd0,   16'd300,   18'h00000, 18'h00000, 1'b0, '{16'd0, STATUS_OK}},
        '{FUNC_WRITE, 9'd1,   9'd1,   16'd400,   18'h00000, 18'h00000, 1'b0, '{16'd0, STATUS_OK}},
        '{FUNC_QUERY, 9'd0,   9'd0,   16'd0,     18'h00000, 18'h00000, 1'b1, '{16'd100, STATUS_OK}},
        '{FUNC_QUERY, 9'd0,   9'd0,   16'd0,     18'h00080, 18'h00080, 1'b1, '{16'd250, STATUS_OK}},
        '{FUNC_QUERY, 9'd0,   9'd0,   16'd0,     18'h3FFFF, 18'h00000, 1'b1, '{16'd0, STATUS_OOB}},
        '{FUNC_QUERY, 9'd0,   9'd0,   16'd0,     18'h00000, 18'h20000, 1'b1, '{16'd0, STATUS_OOB}},
        '{FUNC_QUERY, 9'd0,   9'd0,   16'd0,     18'h1FF01, 18'h00000, 1'b1, '{16'd0, STATUS_OOB}},
        '{FUNC_QUERY, 9'd0,   9'd0,   16'd0,     18'h1FFFF, 18'h00000, 1'b1, '{16'd0, STATUS_OOB}},
        '{FUNC_QUERY, 9'd0,   9'd0,   16'd0,     18'h00000, 18'h1FF00, 1'b1, '{16'd0, STATUS_OOB}},
        '{FUNC_WRITE, 9'd511, 9'd510, 16'hFFFF,  18'h00000, 18'h00000, 1'b0, '{16'd0, STATUS_OK}},
        '{FUNC_WRITE, 9'd511, 9'd511, 16'hFFFF,  18'h00000, 18'h00000, 1'b0, '{16'd0, STATUS_OK}},
        '{FUNC_QUERY, 9'd0,   9'd0,   16'd0,     18'h1FF00, 18'h1FEFF, 1'b1, '{16'hFFFF, STATUS_OK}},
        '{FUNC_WRITE, 9'd2,   9'd0,   16'd0,     18'h00000, 18'h00000, 1'b0, '{16'd0, STATUS_OK}},
        '{FUNC_WRITE, 9'd2,   9'd1,   16'd5,     18'h00000, 18'h00000, 1'b0, '{16'd0, STATUS_OK}},
        '{FUNC_QUERY, 9'd0,   9'd0,   16'd0,     18'h00180, 18'h00040, 1'b1,
          '{16'd0, STATUS_NODATA}},
        '{FUNC_QUERY, 9'd0,   9'd0,   16'd0,     18'h000C8, 18'h00064, 1'b0, '{16'd0, STATUS_OK}},
        '{FUNC_QUERY, 9'd0,   9'd0,   16'd0,     18'h00100, 18'h000C0, 1'b0, '{16'd0, STATUS_OK}}
    };

    phase_t phases [8] = '{
        '{10'd4,    10'd6,    16'h0000, 90},
        '{10'd1,    10'd2,    16'h00FF, 60},
        '{10'd2,    10'd1,    16'h8000, 30},
        '{10'd0,    10'd0,    16'h0001, 20},
        '{10'd512,  10'd512,  16'hFFFF, 130},
        '{10'd1023, 10'd1023, 16'h7FFF, 110},
        '{10'd17,   10'd300,  16'h1234, 130},
        '{10'd3,    10'd2,    16'h0000, 130}
    };

    bilinear_image_sampler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic int lines_in_use();
        return (lines_cfg > IMG_LINES) ? IMG_LINES : int'(lines_cfg);
    endfunction

    function automatic int samps_in_use();
        return (samps_cfg > IMG_SAMPS) ? IMG_SAMPS : int'(samps_cfg);
    endfunction

    function automatic bit locate(input logic signed [QUERY_W-1:0] ql,
                                  input logic signed [QUERY_W-1:0] qs,
                                  output int i00, output int i01,
                                  output int i10, output int i11);
        int nl, ns, l1, s1, l2, s2;
        longint pl, ps;
        nl = lines_in_use();
        ns = samps_in_use();
        pl = ql;
        ps = qs;
        i00 = 0;
        i01 = 0;
        i10 = 0;
        i11 = 0;
        if (pl < 0 || pl > longint'(nl - 1) * ONE || ps < 0 || ps >= longint'(ns - 1) * ONE)
            return 1'b0;
        l1 = int'(pl >>> FRAC);
        s1 = int'(ps >>> FRAC);
        l2 = (l1 + 1 >= nl) ? l1 : l1 + 1;
        s2 = (s1 + 1 >= ns) ? s1 : s1 + 1;
        i00 = l1 * IMG_SAMPS + s1;
        i01 = l1 * IMG_SAMPS + s2;
        i10 = l2 * IMG_SAMPS + s1;
        i11 = l2 * IMG_SAMPS + s2;
        return 1'b1;
    endfunction

    function automatic sample_t blend_at(input logic signed [QUERY_W-1:0] ql,
                                         input logic signed [QUERY_W-1:0] qs);
        sample_t r;
        int i00, i01, i10, i11;
        longint a, b, acc;
        r.value = '0;
        r.status = STATUS_OOB;
        if (!locate(ql, qs, i00, i01, i10, i11))
            return r;
        r.status = STATUS_NODATA;
        if (img_shadow[i00] == nodata_cfg || img_shadow[i01] == nodata_cfg ||
            img_shadow[i10] == nodata_cfg || img_shadow[i11] == nodata_cfg)
            return r;
        a = longint'(ql[FRAC-1:0]);
        b = longint'(qs[FRAC-1:0]);
        acc = (ONE - a) * (ONE - b) * longint'(img_shadow[i00])
            + (ONE - a) * b * longint'(img_shadow[i01])
            + a * (ONE - b) * longint'(img_shadow[i10])
            + a * b * longint'(img_shadow[i11]);
        r.value = VALUE_W'(acc >>> (2 * FRAC));
        r.status = STATUS_OK;
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_beat(input logic [PIX_ADDR_W-1:0] line,
                                                       input logic [PIX_ADDR_W-1:0] samp,
                                                       input logic [PIX_VAL_W-1:0] pix,
                                                       input logic [QUERY_W-1:0] ql,
                                                       input logic [QUERY_W-1:0] qs);
        return {2'b00, qs, ql, pix, samp, line};
    endfunction

    function automatic logic [PIX_VAL_W-1:0] pick_value();
        return ($urandom_range(0, 99) < 15) ? nodata_cfg : PIX_VAL_W'($urandom);
    endfunction

    function automatic logic [QUERY_W-1:0] pos_pick(input int hi, input bit at_edge);
        if (at_edge) begin
            case ($urandom_range(0, 5))
                0: return 18'h3FFFF;
                1: return '0;
                2: return QUERY_W'(hi);
                3: return QUERY_W'(hi + 1);
                4: return 18'h20000;
                default: return 18'h1FFFF;
            endcase
        end
        if (hi < 0)
            return '0;
        case ($urandom_range(0, 3))
            0, 1: return QUERY_W'($urandom_range(0, (hi < 2047) ? hi : 2047));
            2: return QUERY_W'(hi - int'($urandom_range(0, (hi < 511) ? hi : 511)));
            default: return QUERY_W'($urandom_range(0, hi));
        endcase
    endfunction

    task automatic send_beat(input logic func, input logic [S_TDATA_W-1:0] data,
                             input logic pinned, input sample_t typed);
        int gap;
        int idx;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        if (func == FUNC_WRITE) begin
            idx = int'(data[8:0]) * IMG_SAMPS + int'(data[17:9]);
            img_shadow[idx] = data[33:18];
            pix_written[idx] = 1'b1;
        end else begin
            pending_samples.push_back(pinned ? typed : blend_at(data[51:34], data[69:52]));
        end
    endtask

    task automatic send_write(input int line, input int samp, input logic [PIX_VAL_W-1:0] pix);
        send_beat(FUNC_WRITE, pack_beat(PIX_ADDR_W'(line), PIX_ADDR_W'(samp), pix,
                  QUERY_W'($urandom), QUERY_W'($urandom)), 1'b0, '0);
    endtask

    task automatic ensure_written(input int idx);
        if (!pix_written[idx])
            send_write(idx / IMG_SAMPS, idx % IMG_SAMPS, pick_value());
    endtask

    task automatic random_query();
        int lspan, sspan, pick;
        int i00, i01, i10, i11;
        logic [QUERY_W-1:0] ql, qs;
        lspan = (lines_in_use() - 1) * ONE;
        sspan = (samps_in_use() - 1) * ONE - 1;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            ql = QUERY_W'($urandom);
            qs = QUERY_W'($urandom);
        end else begin
            ql = pos_pick(lspan, $urandom_range(0, 99) < 20);
            qs = pos_pick(sspan, $urandom_range(0, 99) < 20);
        end
        if (locate(ql, qs, i00, i01, i10, i11)) begin
            ensure_written(i00);
            ensure_written(i01);
            ensure_written(i10);
            ensure_written(i11);
        end
        send_beat(FUNC_QUERY, pack_beat(PIX_ADDR_W'($urandom), PIX_ADDR_W'($urandom),
                  PIX_VAL_W'($urandom), ql, qs), 1'b0, '0);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NUM_LINES: lines_cfg = val[CNT_W-1:0];
            REG_NUM_SAMPS: samps_cfg = val[CNT_W-1:0];
            default:       nodata_cfg = val[NODATA_W-1:0];
        endcase
        @(posedge aclk);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        aresetn  <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[r]) begin
            send_beat(dir_rows[r].func,
                      pack_beat(dir_rows[r].line, dir_rows[r].samp, dir_rows[r].pix,
                                dir_rows[r].ql, dir_rows[r].qs),
                      dir_rows[r].pinned, dir_rows[r].result);
        end

        for (int p = 0; p < 8; p++) begin
            drain_pipeline();
            reg_write(REG_NUM_LINES, {22'($urandom), phases[p].lines});
            reg_write(REG_NUM_SAMPS, {22'($urandom), phases[p].samps});
            reg_write(REG_NODATA, {16'($urandom), phases[p].nodata});
            if (p == 0)
                hold_off_req = 1'b1;
            phase_start = beats_sent;
            while (beats_sent - phase_start < phases[p].items) begin
                if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 1) == 0)
                        send_write($urandom_range(0, IMG_LINES - 1),
                                   $urandom_range(0, IMG_SAMPS - 1), pick_value());
                    else
                        send_write($urandom_range(0, 8), $urandom_range(0, 8), pick_value());
                end else begin
                    random_query();
                end
            end
        end
        drain_pipeline();

        if (err_count == 0)
            $display("[bilinear_image_sampler] OK");
        else
            $display("[bilinear_image_sampler] ERROR");
        $finish;
    end

    initial begin : result_sink
        int mode;
        int span;
        int tick;
        tick = 0;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 4);
            span = $urandom_range(8, 80);
            repeat (span) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 99) >= 30);
                    2: m_tready <= ($urandom_range(0, 99) >= 90);
                    3: m_tready <= (tick % 3 != 0);
                    default: m_tready <= ((tick / 8) % 2 == 0);
                endcase
                tick++;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        sample_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected beat: value %0d, status %0d", m_tdata, m_tuser);
                err_count++;
            end else begin
                want = pending_samples.pop_front();
                if (m_tdata !== want.value) begin
                    $error("value: expected %0d, actual %0d", want.value, m_tdata);
                    err_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[bilinear_image_sampler] ERROR");
            $finish;
        end
    end

endmodule
